// File: rtl/script_lexer_token_stream_defines.svh
// Assertion macros shared by the scanner RTL.
// Depends on a clock named clk and an active-low reset named arst_n in the using scope.
`ifndef SCRIPT_LEXER_TOKEN_STREAM_DEFINES_SVH
`define SCRIPT_LEXER_TOKEN_STREAM_DEFINES_SVH

// Check a property at every clock edge outside reset.
`define SLTS_CHECK(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define SLTS_CHECK_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/sltok_pkg.sv
// Shared types, token codes and keyword tables of the script lexer.
// No dependencies.
package sltok_pkg;

	localparam int POS_OUT_W  = 24;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	localparam logic [62:0] MAX_VALUE = {63{1'b1}};

	localparam logic [5:0] TK_END      = 6'd0;
	localparam logic [5:0] TK_ERROR    = 6'd1;
	localparam logic [5:0] TK_INTEGER  = 6'd2;
	localparam logic [5:0] TK_REAL     = 6'd3;
	localparam logic [5:0] TK_STRING   = 6'd4;
	localparam logic [5:0] TK_IDENT    = 6'd5;
	localparam logic [5:0] TK_NEWLINE  = 6'd6;
	localparam logic [5:0] TK_LPAREN   = 6'd7;
	localparam logic [5:0] TK_RPAREN   = 6'd8;
	localparam logic [5:0] TK_LBRACK   = 6'd9;
	localparam logic [5:0] TK_RBRACK   = 6'd10;
	localparam logic [5:0] TK_COMMA    = 6'd11;
	localparam logic [5:0] TK_COLON    = 6'd12;
	localparam logic [5:0] TK_PLUS     = 6'd13;
	localparam logic [5:0] TK_MINUS    = 6'd14;
	localparam logic [5:0] TK_STAR     = 6'd15;
	localparam logic [5:0] TK_SLASH    = 6'd16;
	localparam logic [5:0] TK_EQ       = 6'd17;
	localparam logic [5:0] TK_PERCENT  = 6'd18;
	localparam logic [5:0] TK_LT       = 6'd19;
	localparam logic [5:0] TK_LE       = 6'd20;
	localparam logic [5:0] TK_GT       = 6'd21;
	localparam logic [5:0] TK_GE       = 6'd22;
	localparam logic [5:0] TK_NE       = 6'd23;
	localparam logic [5:0] TK_DOT      = 6'd24;
	localparam logic [5:0] TK_ELLIPSIS = 6'd25;
	localparam logic [5:0] TK_KW_BASE  = 6'd26;
	localparam logic [5:0] TK_NOT      = 6'd38;

	localparam logic [63:0] KW_TEXT [20] = '{
		"AND", "BY", "DO", "ELSE", "END", "FALSE", "FOR", "FROM", "FUNCTION", "IF",
		"IN", "INTEGER", "NOT", "NUMBER", "OR", "STRING", "THEN", "TO", "TRUE", "VAR"
	};
	localparam logic [3:0] KW_LEN [20] = '{
		4'd3, 4'd2, 4'd2, 4'd4, 4'd3, 4'd5, 4'd3, 4'd4, 4'd8, 4'd2,
		4'd2, 4'd7, 4'd3, 4'd6, 4'd2, 4'd6, 4'd4, 4'd2, 4'd4, 4'd3
	};

	typedef struct packed {
		logic [5:0]           token_kind;
		logic [62:0]          number_value;
		logic signed [12:0]   decimal_exponent;
		logic [POS_OUT_W-1:0] first_line;
		logic [POS_OUT_W-1:0] first_column;
		logic [POS_OUT_W-1:0] final_line;
		logic [POS_OUT_W-1:0] final_column;
		logic [POS_OUT_W-1:0] begin_offset;
		logic [POS_OUT_W-1:0] finish_offset;
	} tok_t;

	typedef struct packed {
		logic [1:0]     cnt;
		tok_t [2:0]     toks;
	} bundle_t;

	function automatic logic [7:0] kw_char(input logic [4:0] idx, input logic [3:0] pos);
		logic [63:0] txt;
		logic [3:0]  len;
		logic [3:0]  sh;
		txt = '0;
		len = '0;
		if (idx < 5'd20) begin
			txt = KW_TEXT[idx];
			len = KW_LEN[idx];
		end
		sh = len - 4'd1 - pos;
		kw_char = (pos < len) ? txt[{sh[2:0], 3'b000} +: 8] : 8'd0;
	endfunction

	// Next keyword candidate after matching an upper-case letter at position len.
	function automatic logic [4:0] kw_next(input logic [4:0] from, input logic [2:0] len,
		input logic [7:0] c);
		logic       same;
		logic [4:0] r;
		r = '0;
		for (int j = 19; j >= 0; j--) begin
			same = 1'b1;
			for (int k = 0; k < 7; k++) begin
				if (3'(k) < len) begin
					same = same && (kw_char(5'(j), 4'(k)) == kw_char(from, 4'(k)));
				end
			end
			if ((5'(j) >= from) && same && (kw_char(5'(j), {1'b0, len}) == c)) begin
				r = 5'(j + 1);
			end
		end
		kw_next = r;
	endfunction

endpackage

// File: rtl/sltok_front.sv
// Scanner front end: accepts one byte per beat and classifies it into tokens.
// Depends on sltok_pkg; pushes up to three tokens per beat into the token queue.
`include "script_lexer_token_stream_defines.svh"
module sltok_front #(
	parameter int POSITION_BITS = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic              in_end,
	input  logic              q_ready,
	output logic              push,
	output sltok_pkg::bundle_t push_data
);
	import sltok_pkg::*;

	localparam int P = POSITION_BITS;
	localparam logic [P-1:0] POS_ONE = P'(1);

	typedef enum logic [4:0] {
		M_IDLE, M_NL, M_LT, M_GT, M_BANG, M_DOT1, M_DOT2, M_SLASH, M_LCOM,
		M_BLOCK, M_BSTAR, M_STR, M_SESC, M_INT, M_FRAC, M_EXP0, M_EXP,
		M_WORD, M_U8
	} mode_t;

	mode_t        mode_q, mode_d;
	logic [4:0]   kw_q, kw_d;
	logic [62:0]  acc_q, acc_d;
	logic [12:0]  frac_q, frac_d;
	logic [11:0]  exp_q, exp_d;
	logic         neg_q, neg_d;
	logic [P-1:0] line_q, line_d;
	logic [P-1:0] lbo_q, lbo_d;
	logic [P-1:0] off_q, off_d;
	logic [P-1:0] tb_q, tb_d;
	logic [P-1:0] tbl_q, tbl_d;
	logic [P-1:0] tbc_q, tbc_d;
	logic [1:0]   u8p_q, u8p_d;
	logic [20:0]  cp_q, cp_d;
	logic [1:0]   pbb_q, pbb_d;

	logic         accept;
	logic [P-1:0] p, f, len_w;
	logic [7:0]   b, upper;
	logic [3:0]   d;
	logic         isdig, isalpha, ishigh, len_lt9;
	logic [66:0]  acc10;
	logic [15:0]  exp10;
	logic [1:0]   nb_code;
	logic [P-1:0] nb_line, nb_lbo;
	logic [1:0]   nb_pbb;
	logic signed [14:0] e_full;
	logic signed [12:0] e_real;
	logic         fresh;
	logic [1:0]   n;
	tok_t [2:0]   toks;

	function automatic tok_t mk(input logic [5:0] kind, input logic [62:0] val,
		input logic signed [12:0] ex, input logic [P-1:0] bl, input logic [P-1:0] bc,
		input logic [P-1:0] fl, input logic [P-1:0] lbo, input logic [P-1:0] bo,
		input logic [P-1:0] fo);
		tok_t         t;
		logic [P-1:0] fc;
		fc = fo - lbo;
		t.token_kind       = kind;
		t.number_value     = val;
		t.decimal_exponent = ex;
		t.first_line       = POS_OUT_W'(bl);
		t.first_column     = POS_OUT_W'(bc);
		t.final_line       = POS_OUT_W'(fl);
		t.final_column     = POS_OUT_W'(fc);
		t.begin_offset     = POS_OUT_W'(bo);
		t.finish_offset    = POS_OUT_W'(fo);
		mk = t;
	endfunction

	assign accept   = in_valid && q_ready;
	assign in_ready = q_ready;

	assign b       = in_byte;
	assign p       = off_q;
	assign f       = off_q + POS_ONE;
	assign d       = in_byte[3:0];
	assign isdig   = (b >= 8'h30) && (b <= 8'h39);
	assign isalpha = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
	assign ishigh  = (b >= 8'h80) && (b <= 8'hF4);
	assign upper   = (b >= 8'h61) ? b - 8'd32 : b;
	assign len_w   = p - tb_q;
	assign len_lt9 = ((len_w >> 4) == '0) && (len_w[3:0] < 4'd9);
	assign acc10   = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + {63'b0, d};
	assign exp10   = ({4'b0, exp_q} << 3) + ({4'b0, exp_q} << 1) + {12'b0, d};

	always_comb begin
		nb_code = (b == 8'd13) ? 2'd1 : (b == 8'd10) ? 2'd2 : 2'd0;
		nb_line = line_q;
		nb_lbo  = lbo_q;
		nb_pbb  = 2'd0;
		if (nb_code != 2'd0) begin
			if ((pbb_q != 2'd0) && (pbb_q != nb_code)) begin
				nb_pbb = 2'd0;
			end else begin
				nb_line = line_q + POS_ONE;
				nb_pbb  = nb_code;
			end
			nb_lbo = f;
		end
	end

	always_comb begin
		mode_d = mode_q;
		kw_d   = kw_q;
		acc_d  = acc_q;
		frac_d = frac_q;
		exp_d  = exp_q;
		neg_d  = neg_q;
		line_d = line_q;
		lbo_d  = lbo_q;
		off_d  = f;
		tb_d   = tb_q;
		tbl_d  = tbl_q;
		tbc_d  = tbc_q;
		u8p_d  = u8p_q;
		cp_d   = cp_q;
		pbb_d  = pbb_q;
		fresh  = 1'b0;
		n      = 2'd0;
		toks   = '0;
		e_full = '0;
		e_real = '0;

		if (!in_end) begin
			case (mode_q)
				M_NL: begin
					if ((pbb_q == 2'd1 && b == 8'd10) || (pbb_q == 2'd2 && b == 8'd13)) begin
						line_d = line_q + POS_ONE;
						lbo_d  = f;
						toks[n] = mk(TK_NEWLINE, '0, '0, tbl_q, tbc_q, line_d, lbo_d, tb_q, f);
						n = n + 2'd1;
						mode_d = M_IDLE;
						pbb_d  = 2'd0;
					end else begin
						fresh = 1'b1;
					end
				end
				M_LT, M_GT, M_BANG: begin
					if (b == "=") begin
						toks[n] = mk((mode_q == M_LT) ? TK_LE : (mode_q == M_GT) ? TK_GE : TK_NE,
							'0, '0, tbl_q, tbc_q, line_q, lbo_q, tb_q, f);
						n = n + 2'd1;
						mode_d = M_IDLE;
					end else begin
						fresh = 1'b1;
					end
				end
				M_DOT1: begin
					if (b == ".") mode_d = M_DOT2;
					else fresh = 1'b1;
				end
				M_DOT2: begin
					if (b == ".") begin
						toks[n] = mk(TK_ELLIPSIS, '0, '0, tbl_q, tbc_q, line_q, lbo_q, tb_q, f);
						n = n + 2'd1;
						mode_d = M_IDLE;
					end else begin
						fresh = 1'b1;
					end
				end
				M_SLASH: begin
					if (b == "/") begin
						mode_d = M_LCOM;
					end else if (b == "*") begin
						mode_d = M_BLOCK;
						pbb_d  = 2'd0;
					end else begin
						fresh = 1'b1;
					end
				end
				M_LCOM: begin
					if (b == 8'd13 || b == 8'd10) begin
						mode_d = M_IDLE;
						fresh  = 1'b1;
					end
				end
				M_BLOCK: begin
					if (b == "*") begin
						mode_d = M_BSTAR;
						pbb_d  = 2'd0;
					end else begin
						line_d = nb_line;
						lbo_d  = nb_lbo;
						pbb_d  = nb_pbb;
					end
				end
				M_BSTAR: begin
					if (b == "/") begin
						mode_d = M_IDLE;
					end else if (b != "*") begin
						mode_d = M_BLOCK;
						line_d = nb_line;
						lbo_d  = nb_lbo;
						pbb_d  = nb_pbb;
					end
				end
				M_STR: begin
					if (b == "\"") begin
						toks[n] = mk(TK_STRING, '0, '0, tbl_q, tbc_q, line_q, lbo_q, tb_q, f);
						n = n + 2'd1;
						mode_d = M_IDLE;
						pbb_d  = 2'd0;
					end else if (b == "\\") begin
						mode_d = M_SESC;
						pbb_d  = 2'd0;
					end else begin
						line_d = nb_line;
						lbo_d  = nb_lbo;
						pbb_d  = nb_pbb;
					end
				end
				M_SESC: begin
					if (b == "\\" || b == "n" || b == "r" || b == "\"") mode_d = M_STR;
					else fresh = 1'b1;
				end
				M_INT: begin
					if (isdig) begin
						acc_d = (acc10 > {4'b0, MAX_VALUE}) ? MAX_VALUE : acc10[62:0];
					end else if (b == ".") begin
						mode_d = M_FRAC;
					end else if (b == "e" || b == "E") begin
						mode_d = M_EXP0;
					end else begin
						fresh = 1'b1;
					end
				end
				M_FRAC: begin
					if (isdig) begin
						if (acc10 - {63'b0, d} + 67'd9 <= {4'b0, MAX_VALUE}) begin
							acc_d = acc10[62:0];
							if (frac_q != 13'h1FFF) frac_d = frac_q + 13'd1;
						end
					end else if (b == "e" || b == "E") begin
						mode_d = M_EXP0;
					end else begin
						fresh = 1'b1;
					end
				end
				M_EXP0, M_EXP: begin
					if (isdig) begin
						exp_d  = (exp10 > 16'd4095) ? 12'd4095 : exp10[11:0];
						mode_d = M_EXP;
					end else if (mode_q == M_EXP0 && b == "+") begin
						mode_d = M_EXP;
					end else if (mode_q == M_EXP0 && b == "-") begin
						neg_d  = 1'b1;
						mode_d = M_EXP;
					end else begin
						fresh = 1'b1;
					end
				end
				M_U8: begin
					if (u8p_q != 2'd0) begin
						case (u8p_q)
							2'd1:    cp_d = cp_q | {15'b0, b[5:0]};
							2'd2:    cp_d = cp_q | {9'b0, b[5:0], 6'b0};
							default: cp_d = cp_q | {3'b0, b[5:0], 12'b0};
						endcase
						u8p_d = u8p_q - 2'd1;
					end
					if (u8p_d == 2'd0) begin
						if (cp_d == 21'h2260) begin
							toks[n] = mk(TK_NE, '0, '0, tbl_q, tbc_q, line_q, lbo_q, tb_q, f);
							n = n + 2'd1;
							mode_d = M_IDLE;
						end else begin
							mode_d = M_WORD;
							kw_d   = '0;
						end
					end
				end
				M_WORD: begin
					if (u8p_q != 2'd0) begin
						u8p_d = u8p_q - 2'd1;
					end else if (isalpha) begin
						if (kw_q != 5'd0) begin
							kw_d = ((len_w >> 3) != '0) ? 5'd0 :
								kw_next(kw_q - 5'd1, len_w[2:0], upper);
						end
					end else if (isdig) begin
						kw_d = '0;
					end else if (ishigh) begin
						kw_d  = '0;
						u8p_d = (b <= 8'hDF) ? 2'd1 : (b <= 8'hEF) ? 2'd2 : 2'd3;
					end else begin
						fresh = 1'b1;
					end
				end
				default: fresh = 1'b1;
			endcase
		end

		if (in_end || fresh) begin
			e_full = (neg_d ? -$signed({3'b0, exp_d}) : $signed({3'b0, exp_d}))
				- $signed({2'b0, frac_d});
			e_real = (e_full < -15'sd4096) ? -13'sd4096 :
				(e_full > 15'sd4095) ? 13'sd4095 : e_full[12:0];
			case (mode_d)
				M_NL: begin
					line_d = line_d + POS_ONE;
					lbo_d  = p;
					toks[n] = mk(TK_NEWLINE, '0, '0, tbl_d, tbc_d, line_d, lbo_d, tb_d, p);
					n = n + 2'd1;
				end
				M_LT: begin
					toks[n] = mk(TK_LT, '0, '0, tbl_d, tbc_d, line_d, lbo_d, tb_d, p);
					n = n + 2'd1;
				end
				M_GT: begin
					toks[n] = mk(TK_GT, '0, '0, tbl_d, tbc_d, line_d, lbo_d, tb_d, p);
					n = n + 2'd1;
				end
				M_BANG: begin
					toks[n] = mk(TK_NOT, '0, '0, tbl_d, tbc_d, line_d, lbo_d, tb_d, p);
					n = n + 2'd1;
				end
				M_SLASH: begin
					toks[n] = mk(TK_SLASH, '0, '0, tbl_d, tbc_d, line_d, lbo_d, tb_d, p);
					n = n + 2'd1;
				end
				M_DOT1: begin
					toks[n] = mk(TK_DOT, '0, '0, tbl_d, tbc_d, line_d, lbo_d, tb_d, p);
					n = n + 2'd1;
				end
				M_DOT2: begin
					toks[n] = mk(TK_DOT, '0, '0, tbl_d, tbc_d, line_d, lbo_d, tb_d,
						tb_d + POS_ONE);
					n = n + 2'd1;
					toks[n] = mk(TK_DOT, '0, '0, tbl_d, tbc_d + POS_ONE, line_d, lbo_d,
						tb_d + POS_ONE, p);
					n = n + 2'd1;
				end
				M_STR, M_SESC, M_U8: begin
					toks[n] = mk(TK_ERROR, '0, '0, tbl_d, tbc_d, line_d, lbo_d, tb_d, p);
					n = n + 2'd1;
				end
				M_INT: begin
					toks[n] = mk(TK_INTEGER, acc_d, '0, tbl_d, tbc_d, line_d, lbo_d, tb_d, p);
					n = n + 2'd1;
				end
				M_FRAC, M_EXP0, M_EXP: begin
					toks[n] = mk(TK_REAL, acc_d, e_real, tbl_d, tbc_d, line_d, lbo_d, tb_d, p);
					n = n + 2'd1;
				end
				M_WORD: begin
					if (u8p_d != 2'd0) begin
						toks[n] = mk(TK_ERROR, '0, '0, tbl_d, tbc_d, line_d, lbo_d, tb_d, p);
					end else if (kw_d != 5'd0 && len_lt9 &&
						kw_char(kw_d - 5'd1, len_w[3:0]) == 8'd0) begin
						toks[n] = mk(TK_KW_BASE + {1'b0, kw_d} - 6'd1, '0, '0, tbl_d, tbc_d,
							line_d, lbo_d, tb_d, p);
					end else begin
						toks[n] = mk(TK_IDENT, '0, '0, tbl_d, tbc_d, line_d, lbo_d, tb_d, p);
					end
					n = n + 2'd1;
				end
				default: ;
			endcase
			mode_d = M_IDLE;
			u8p_d  = 2'd0;
			pbb_d  = 2'd0;
		end

		if (in_end) begin
			toks[n] = mk(TK_END, '0, '0, line_d, p - lbo_d, line_d, lbo_d, p, p);
			n = n + 2'd1;
			mode_d = M_IDLE;
			kw_d   = '0;
			acc_d  = '0;
			frac_d = '0;
			exp_d  = '0;
			neg_d  = 1'b0;
			line_d = POS_ONE;
			lbo_d  = '0;
			off_d  = '0;
			tb_d   = '0;
			tbl_d  = POS_ONE;
			tbc_d  = '0;
			u8p_d  = '0;
			cp_d   = '0;
			pbb_d  = '0;
		end else if (fresh) begin
			tb_d   = p;
			tbl_d  = line_d;
			tbc_d  = p - lbo_d;
			acc_d  = '0;
			frac_d = '0;
			exp_d  = '0;
			neg_d  = 1'b0;
			kw_d   = '0;
			u8p_d  = '0;
			cp_d   = '0;
			pbb_d  = '0;
			mode_d = M_IDLE;
			if (isdig) begin
				acc_d  = {59'b0, d};
				mode_d = M_INT;
			end else if (isalpha) begin
				kw_d   = kw_next(5'd0, 3'd0, upper);
				mode_d = M_WORD;
			end else if (ishigh) begin
				if (b <= 8'hDF) begin
					u8p_d = 2'd1;
					cp_d  = {10'b0, b[4:0], 6'b0};
				end else if (b <= 8'hEF) begin
					u8p_d = 2'd2;
					cp_d  = {5'b0, b[3:0], 12'b0};
				end else begin
					u8p_d = 2'd3;
					cp_d  = {b[2:0], 18'b0};
				end
				mode_d = M_U8;
			end else begin
				case (b)
					"\"": mode_d = M_STR;
					"/":  mode_d = M_SLASH;
					"<":  mode_d = M_LT;
					">":  mode_d = M_GT;
					"!":  mode_d = M_BANG;
					".":  mode_d = M_DOT1;
					8'd13: begin
						mode_d = M_NL;
						pbb_d  = 2'd1;
					end
					8'd10: begin
						mode_d = M_NL;
						pbb_d  = 2'd2;
					end
					" ", 8'd9: ;
					default: begin
						case (b)
							"(":     toks[n] = mk(TK_LPAREN, '0, '0, tbl_d, tbc_d, line_d, lbo_d, tb_d, f);
							")":     toks[n] = mk(TK_RPAREN, '0, '0, tbl_d, tbc_d, line_d, lbo_d, tb_d, f);
							"[":     toks[n] = mk(TK_LBRACK, '0, '0, tbl_d, tbc_d, line_d, lbo_d, tb_d, f);
							"]":     toks[n] = mk(TK_RBRACK, '0, '0, tbl_d, tbc_d, line_d, lbo_d, tb_d, f);
							",":     toks[n] = mk(TK_COMMA, '0, '0, tbl_d, tbc_d, line_d, lbo_d, tb_d, f);
							":":     toks[n] = mk(TK_COLON, '0, '0, tbl_d, tbc_d, line_d, lbo_d, tb_d, f);
							"+":     toks[n] = mk(TK_PLUS, '0, '0, tbl_d, tbc_d, line_d, lbo_d, tb_d, f);
							"-":     toks[n] = mk(TK_MINUS, '0, '0, tbl_d, tbc_d, line_d, lbo_d, tb_d, f);
							"*":     toks[n] = mk(TK_STAR, '0, '0, tbl_d, tbc_d, line_d, lbo_d, tb_d, f);
							"=":     toks[n] = mk(TK_EQ, '0, '0, tbl_d, tbc_d, line_d, lbo_d, tb_d, f);
							"%":     toks[n] = mk(TK_PERCENT, '0, '0, tbl_d, tbc_d, line_d, lbo_d, tb_d, f);
							default: toks[n] = mk(TK_ERROR, '0, '0, tbl_d, tbc_d, line_d, lbo_d, tb_d, f);
						endcase
						n = n + 2'd1;
					end
				endcase
			end
		end
	end

	assign push           = accept && (n != 2'd0);
	assign push_data.cnt  = n;
	assign push_data.toks = toks;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			kw_q   <= '0;
			acc_q  <= '0;
			frac_q <= '0;
			exp_q  <= '0;
			neg_q  <= 1'b0;
			line_q <= POS_ONE;
			lbo_q  <= '0;
			off_q  <= '0;
			tb_q   <= '0;
			tbl_q  <= POS_ONE;
			tbc_q  <= '0;
			u8p_q  <= '0;
			cp_q   <= '0;
			pbb_q  <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			kw_q   <= kw_d;
			acc_q  <= acc_d;
			frac_q <= frac_d;
			exp_q  <= exp_d;
			neg_q  <= neg_d;
			line_q <= line_d;
			lbo_q  <= lbo_d;
			off_q  <= off_d;
			tb_q   <= tb_d;
			tbl_q  <= tbl_d;
			tbc_q  <= tbc_d;
			u8p_q  <= u8p_d;
			cp_q   <= cp_d;
			pbb_q  <= pbb_d;
		end
	end

	`SLTS_CHECK_NEXT(a_end_resets, accept && in_end, line_q == POS_ONE && off_q == '0 && mode_q == M_IDLE, "end beat did not reset scanner state")

endmodule

// File: rtl/sltok_fifo.sv
// Token queue between scanner front end and output stage, one bundle per entry.
// Depends on sltok_pkg.
`include "script_lexer_token_stream_defines.svh"
module sltok_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  sltok_pkg::bundle_t push_data,
	output logic               ready,
	input  logic               pop,
	output sltok_pkg::bundle_t head,
	output logic               head_valid
);
	import sltok_pkg::*;

	bundle_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_q, rd_q;
	logic [FIFO_AW:0]     count_q;

	assign ready      = count_q != (FIFO_AW + 1)'(FIFO_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	`SLTS_CHECK(a_count_range, count_q <= (FIFO_AW + 1)'(FIFO_DEPTH), "token queue count out of range")
	`SLTS_CHECK_NEXT(a_push_counts, push && !pop, count_q == $past(count_q) + 1'b1, "push not reflected in queue count")

endmodule

// File: rtl/sltok_back.sv
// Output stage: unpacks queued bundles and presents one token per beat.
// Depends on sltok_pkg; marks the last token of each bundle.
module sltok_back (
	input  logic               clk,
	input  logic               arst_n,
	input  sltok_pkg::bundle_t head,
	input  logic               head_valid,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output sltok_pkg::tok_t    out_tok,
	output logic               out_last
);
	import sltok_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q;
	logic       last_q;
	tok_t       tok_q;
	logic       load;
	logic       at_last;

	assign load      = head_valid && (!valid_q || out_ready);
	assign at_last   = (idx_q + 2'd1) == head.cnt;
	assign pop       = load && at_last;
	assign out_valid = valid_q;
	assign out_tok   = tok_q;
	assign out_last  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= at_last ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tok_q  <= head.toks[idx_q];
			last_q <= at_last;
		end
	end

endmodule

// File: rtl/script_lexer_token_stream.sv
// Script lexer: one source byte per beat in, one token per beat out.
// Tokens pass through the token queue and a registered output stage after the byte that completes them.
// Throughput: one byte per cycle while the token queue has room and each byte yields at most one token;
// bytes yielding two or three tokens are sent one token per output beat, buffered by a 4-deep queue.
// Reset (arst_n low, asynchronous) returns the scanner to line 1, offset 0, and empties the queue.
module script_lexer_token_stream #(
	parameter int POSITION_BITS = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,  // text_byte
	input  logic         s_tuser,  // end_of_text
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [223:0] m_tdata,  // number_value, decimal_exponent, first_line, first_column,
	                               // final_line, final_column, begin_offset, finish_offset, pad
	output logic [5:0]   m_tuser,  // token_kind
	output logic         m_tlast   // last_in_run
);
	import sltok_pkg::*;

	logic    push, q_ready, pop, head_valid;
	bundle_t push_data, head;
	tok_t    tok;

	sltok_front #(
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.in_end   (s_tuser),
		.q_ready  (q_ready),
		.push     (push),
		.push_data(push_data)
	);

	sltok_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.ready     (q_ready),
		.pop       (pop),
		.head      (head),
		.head_valid(head_valid)
	);

	sltok_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_valid(head_valid),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_tok   (tok),
		.out_last  (m_tlast)
	);

	assign m_tuser = tok.token_kind;
	assign m_tdata = {4'b0, tok.finish_offset, tok.begin_offset, tok.final_column,
		tok.final_line, tok.first_column, tok.first_line, tok.decimal_exponent,
		tok.number_value};

endmodule

// File: test/testbench.sv
// Self-checking bench for script_lexer_token_stream: byte stream in, token beats out.
// Uses sltok_pkg for token codes; holds its own scanner model in a scoreboard class.
module testbench;
	import sltok_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int ITEM_TARGET = 400;

	typedef enum int {
		SC_IDLE, SC_NL, SC_LT, SC_GT, SC_BANG, SC_DOT1, SC_DOT2, SC_SLASH, SC_LCOM,
		SC_BLOCK, SC_BSTAR, SC_STR, SC_SESC, SC_INT, SC_FRAC, SC_EXP0, SC_EXP,
		SC_WORD, SC_U8
	} scan_e;

	typedef struct {
		logic [5:0]  kind;
		logic [62:0] val;
		logic [12:0] ex;
		logic [23:0] fl, fc, ll, lc, bo, fo;
		bit          last;
	} token_s;

	class token_scoreboard;
		localparam logic [62:0] TOP = {63{1'b1}};
		string kw[20] = '{"AND", "BY", "DO", "ELSE", "END", "FALSE", "FOR", "FROM",
			"FUNCTION", "IF", "IN", "INTEGER", "NOT", "NUMBER", "OR", "STRING", "THEN",
			"TO", "TRUE", "VAR"};
		token_s      due_tokens[$];
		token_s      step_tokens[$];
		int          errors;
		scan_e       mode;
		int          node, frac, expo, u8left, brk;
		bit          eneg;
		logic [62:0] acc;
		logic [20:0] cp;
		logic [23:0] line, lbeg, pos, tbeg, tline, tcol;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			mode = SC_IDLE; node = 0; acc = 0; frac = 0; expo = 0; eneg = 0;
			line = 1; lbeg = 0; pos = 0; tbeg = 0; tline = 1; tcol = 0;
			u8left = 0; cp = 0; brk = 0;
		endfunction

		function void push(logic [5:0] kind, logic [62:0] val, int ex, logic [23:0] bl,
			logic [23:0] bc, logic [23:0] bo, logic [23:0] fo);
			token_s t;
			if (step_tokens.size() >= 3) return;
			t.kind = kind; t.val = val; t.ex = 13'(ex);
			t.fl = bl; t.fc = bc; t.ll = line; t.lc = fo - lbeg; t.bo = bo; t.fo = fo;
			t.last = 0;
			step_tokens.push_back(t);
		endfunction

		function void put(logic [5:0] kind, logic [62:0] val, int ex, logic [23:0] fo);
			push(kind, val, ex, tline, tcol, tbeg, fo);
		endfunction

		function int kw_char(int j, int k);
			return (k < kw[j].len()) ? int'(kw[j][k]) : 0;
		endfunction

		function int kw_step(int from, int len, int c);
			bit same;
			if (len >= 8) return 0;
			for (int j = from; j < 20; j++) begin
				same = 1;
				for (int k = 0; k < len; k++)
					if (kw_char(j, k) != kw_char(from, k)) same = 0;
				if (same && kw_char(j, len) == c) return j + 1;
			end
			return 0;
		endfunction

		function int real_exp();
			int e;
			e = eneg ? -expo : expo;
			e -= frac;
			if (e < -4096) e = -4096;
			if (e > 4095) e = 4095;
			return e;
		endfunction

		function void note_break(int b, logic [23:0] p);
			int code;
			code = (b == 13) ? 1 : (b == 10) ? 2 : 0;
			if (code == 0) begin
				brk = 0;
				return;
			end
			if (brk != 0 && brk != code) brk = 0;
			else begin
				line++;
				brk = code;
			end
			lbeg = p + 1;
		endfunction

		function void flush(logic [23:0] p);
			logic [23:0] len;
			case (mode)
				SC_NL: begin
					line++;
					lbeg = p;
					put(TK_NEWLINE, 0, 0, p);
				end
				SC_LT: put(TK_LT, 0, 0, p);
				SC_GT: put(TK_GT, 0, 0, p);
				SC_BANG: put(TK_NOT, 0, 0, p);
				SC_SLASH: put(TK_SLASH, 0, 0, p);
				SC_DOT1: put(TK_DOT, 0, 0, p);
				SC_DOT2: begin
					put(TK_DOT, 0, 0, tbeg + 1);
					push(TK_DOT, 0, 0, tline, tcol + 1, tbeg + 1, p);
				end
				SC_STR, SC_SESC, SC_U8: put(TK_ERROR, 0, 0, p);
				SC_INT: put(TK_INTEGER, acc, 0, p);
				SC_FRAC, SC_EXP0, SC_EXP: put(TK_REAL, acc, real_exp(), p);
				SC_WORD: begin
					len = p - tbeg;
					if (u8left != 0) put(TK_ERROR, 0, 0, p);
					else if (node != 0 && len == 24'(kw[node - 1].len()))
						put(TK_KW_BASE + 6'(node - 1), 0, 0, p);
					else put(TK_IDENT, 0, 0, p);
				end
				default: ;
			endcase
			mode = SC_IDLE;
			u8left = 0;
			brk = 0;
		endfunction

		function void start(int b, logic [23:0] p);
			logic [23:0] f;
			f = p + 1;
			tbeg = p; tline = line; tcol = p - lbeg;
			acc = 0; frac = 0; expo = 0; eneg = 0; node = 0; u8left = 0; cp = 0; brk = 0;
			mode = SC_IDLE;
			if (b >= "0" && b <= "9") begin
				acc = 63'(b - "0");
				mode = SC_INT;
				return;
			end
			if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z")) begin
				node = kw_step(0, 0, (b >= "a") ? b - 32 : b);
				mode = SC_WORD;
				return;
			end
			case (b)
				"\"": mode = SC_STR;
				"(": put(TK_LPAREN, 0, 0, f);
				")": put(TK_RPAREN, 0, 0, f);
				"[": put(TK_LBRACK, 0, 0, f);
				"]": put(TK_RBRACK, 0, 0, f);
				",": put(TK_COMMA, 0, 0, f);
				":": put(TK_COLON, 0, 0, f);
				"+": put(TK_PLUS, 0, 0, f);
				"-": put(TK_MINUS, 0, 0, f);
				"*": put(TK_STAR, 0, 0, f);
				"=": put(TK_EQ, 0, 0, f);
				"%": put(TK_PERCENT, 0, 0, f);
				"/": mode = SC_SLASH;
				"<": mode = SC_LT;
				">": mode = SC_GT;
				"!": mode = SC_BANG;
				".": mode = SC_DOT1;
				13: begin
					mode = SC_NL;
					brk = 1;
				end
				10: begin
					mode = SC_NL;
					brk = 2;
				end
				" ", 9: ;
				default: begin
					if (b >= 'h80 && b <= 'hF4) begin
						if (b <= 'hDF) begin
							u8left = 1;
							cp = 21'(b & 'h1F) << 6;
						end else if (b <= 'hEF) begin
							u8left = 2;
							cp = 21'(b & 'h0F) << 12;
						end else begin
							u8left = 3;
							cp = 21'(b & 'h07) << 18;
						end
						mode = SC_U8;
					end else put(TK_ERROR, 0, 0, f);
				end
			endcase
		endfunction

		function void note_input(logic [7:0] text, bit eot);
			int b, d;
			bit fresh, isdig;
			logic [23:0] p, f;
			b = text; p = pos; f = p + 1; d = b - "0";
			isdig = (b >= "0" && b <= "9");
			fresh = 0;
			step_tokens.delete();
			if (eot) begin
				flush(p);
				push(TK_END, 0, 0, line, p - lbeg, p, p);
				clear();
			end else begin
				case (mode)
					SC_NL:
						if ((brk == 1 && b == 10) || (brk == 2 && b == 13)) begin
							line++;
							lbeg = f;
							put(TK_NEWLINE, 0, 0, f);
							mode = SC_IDLE;
							brk = 0;
						end else fresh = 1;
					SC_LT, SC_GT, SC_BANG:
						if (b == "=") begin
							put((mode == SC_LT) ? TK_LE : (mode == SC_GT) ? TK_GE : TK_NE,
								0, 0, f);
							mode = SC_IDLE;
						end else fresh = 1;
					SC_DOT1: if (b == ".") mode = SC_DOT2; else fresh = 1;
					SC_DOT2:
						if (b == ".") begin
							put(TK_ELLIPSIS, 0, 0, f);
							mode = SC_IDLE;
						end else fresh = 1;
					SC_SLASH:
						if (b == "/") mode = SC_LCOM;
						else if (b == "*") begin
							mode = SC_BLOCK;
							brk = 0;
						end else fresh = 1;
					SC_LCOM:
						if (b == 13 || b == 10) begin
							mode = SC_IDLE;
							fresh = 1;
						end
					SC_BLOCK:
						if (b == "*") begin
							mode = SC_BSTAR;
							brk = 0;
						end else note_break(b, p);
					SC_BSTAR:
						if (b == "/") mode = SC_IDLE;
						else if (b != "*") begin
							mode = SC_BLOCK;
							note_break(b, p);
						end
					SC_STR:
						if (b == "\"") begin
							put(TK_STRING, 0, 0, f);
							mode = SC_IDLE;
							brk = 0;
						end else if (b == "\\") begin
							mode = SC_SESC;
							brk = 0;
						end else note_break(b, p);
					SC_SESC:
						if (b == "\\" || b == "n" || b == "r" || b == "\"") mode = SC_STR;
						else fresh = 1;
					SC_INT:
						if (isdig) begin
							if (64'(acc) > (64'(TOP) - 64'(d)) / 10) acc = TOP;
							else acc = acc * 10 + 63'(d);
						end else if (b == ".") mode = SC_FRAC;
						else if (b == "e" || b == "E") mode = SC_EXP0;
						else fresh = 1;
					SC_FRAC:
						if (isdig) begin
							if (64'(acc) <= (64'(TOP) - 9) / 10) begin
								acc = acc * 10 + 63'(d);
								if (frac < 8191) frac++;
							end
						end else if (b == "e" || b == "E") mode = SC_EXP0;
						else fresh = 1;
					SC_EXP0, SC_EXP:
						if (isdig) begin
							expo = expo * 10 + d;
							if (expo > 4095) expo = 4095;
							mode = SC_EXP;
						end else if (mode == SC_EXP0 && b == "+") mode = SC_EXP;
						else if (mode == SC_EXP0 && b == "-") begin
							eneg = 1;
							mode = SC_EXP;
						end else fresh = 1;
					SC_U8: begin
						if (u8left > 0) begin
							cp |= 21'(b & 'h3F) << (6 * (u8left - 1));
							u8left--;
						end
						if (u8left == 0) begin
							if (cp == 21'h2260) begin
								put(TK_NE, 0, 0, f);
								mode = SC_IDLE;
							end else begin
								mode = SC_WORD;
								node = 0;
							end
						end
					end
					SC_WORD:
						if (u8left > 0) u8left--;
						else if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z")) begin
							if (node != 0)
								node = kw_step(node - 1, int'(p - tbeg), (b >= "a") ? b - 32 : b);
						end else if (isdig) node = 0;
						else if (b >= 'h80 && b <= 'hF4) begin
							node = 0;
							u8left = (b <= 'hDF) ? 1 : (b <= 'hEF) ? 2 : 3;
						end else fresh = 1;
					default: fresh = 1;
				endcase
				if (fresh) begin
					flush(p);
					start(b, p);
				end
				pos = f;
			end
			if (step_tokens.size() > 0) step_tokens[$].last = 1;
			foreach (step_tokens[i]) due_tokens.push_back(step_tokens[i]);
		endfunction

		function void field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			end
		endfunction

		function void check_token(logic [5:0] kind, logic [223:0] data, bit last);
			token_s t;
			if (due_tokens.size() == 0) begin
				errors++;
				$display("%0t: unexpected token, expected none, actual kind %0d", $time, kind);
				return;
			end
			t = due_tokens.pop_front();
			field("token_kind", t.kind, kind);
			field("number_value", t.val, data[62:0]);
			field("decimal_exponent", t.ex, data[75:63]);
			field("first_line", t.fl, data[99:76]);
			field("first_column", t.fc, data[123:100]);
			field("final_line", t.ll, data[147:124]);
			field("final_column", t.lc, data[171:148]);
			field("begin_offset", t.bo, data[195:172]);
			field("finish_offset", t.fo, data[219:196]);
			field("last_in_run", t.last, last);
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [223:0] m_tdata;
	logic [5:0]   m_tuser;
	logic         m_tlast;

	token_scoreboard lexer_model = new();
	logic [8:0]      text_items[$];
	int              taken;
	int              cycles;
	bit              calm;

	script_lexer_token_stream dut (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task add_text(string s);
		for (int i = 0; i < s.len(); i++) text_items.push_back({1'b0, s[i]});
	endtask

	task add_byte(logic [7:0] b);
		text_items.push_back({1'b0, b});
	endtask

	task add_end();
		text_items.push_back({1'b1, 8'($urandom)});
	endtask

	task add_digits(int n);
		for (int i = 0; i < n; i++) add_byte(8'("0" + $urandom_range(0, 9)));
	endtask

	task add_letter(bit any_case);
		logic [7:0] c;
		c = 8'("A" + $urandom_range(0, 25));
		add_byte((any_case && $urandom_range(0, 1)) ? c + 8'd32 : c);
	endtask

	task add_fragment();
		string ops[] = '{"(", ")", "[", "]", ",", ":", "+", "-", "*", "/", "=", "%", "<",
			"<=", ">", ">=", "!=", "!", ".", "..", "..."};
		string w;
		int pick;
		pick = $urandom_range(0, 13);
		case (pick)
			0: begin
				w = lexer_model.kw[$urandom_range(0, 19)];
				for (int i = 0; i < w.len(); i++)
					add_byte($urandom_range(0, 1) ? w[i] + 8'd32 : w[i]);
				if ($urandom_range(0, 3) == 0) add_letter(1);
			end
			1: begin
				add_letter(1);
				repeat ($urandom_range(0, 5))
					if ($urandom_range(0, 2) == 0) add_digits(1); else add_letter(1);
			end
			2: add_digits(($urandom_range(0, 5) == 0) ? $urandom_range(18, 24) : $urandom_range(1, 4));
			3: begin
				add_digits($urandom_range(1, 3));
				add_byte(".");
				add_digits(($urandom_range(0, 5) == 0) ? $urandom_range(15, 22) : $urandom_range(0, 3));
				if ($urandom_range(0, 1)) begin
					add_byte($urandom_range(0, 1) ? "e" : "E");
					case ($urandom_range(0, 2))
						0: add_byte("+");
						1: add_byte("-");
						default: ;
					endcase
					add_digits($urandom_range(0, 5));
				end
			end
			4: begin
				add_byte("\"");
				repeat ($urandom_range(0, 6))
					case ($urandom_range(0, 7))
						0: add_text("\\n");
						1: add_text("\\\"");
						2: add_byte($urandom_range(0, 1) ? 8'd13 : 8'd10);
						3: begin
							add_byte("\\");
							add_byte(8'($urandom_range(0, 9) == 0 ? $urandom : "q"));
						end
						default: add_byte(8'($urandom_range(32, 126)));
					endcase
				if ($urandom_range(0, 7) != 0) add_byte("\"");
			end
			5: add_text(ops[$urandom_range(0, ops.size() - 1)]);
			6: repeat ($urandom_range(1, 3)) add_byte($urandom_range(0, 1) ? 8'd13 : 8'd10);
			7: begin
				add_text("//");
				repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(32, 126)));
				add_byte($urandom_range(0, 1) ? 8'd13 : 8'd10);
			end
			8: begin
				add_text("/*");
				repeat ($urandom_range(0, 5))
					case ($urandom_range(0, 3))
						0: add_byte("*");
						1: add_byte($urandom_range(0, 1) ? 8'd13 : 8'd10);
						default: add_byte(8'($urandom_range(32, 126)));
					endcase
				if ($urandom_range(0, 7) != 0) add_text("*/");
			end
			9: begin
				if ($urandom_range(0, 1)) begin
					add_byte(8'hE2); add_byte(8'h89); add_byte(8'hA0);
				end else begin
					add_byte(8'($urandom_range(8'h80, 8'hF4)));
					repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
				end
			end
			10: add_byte($urandom_range(0, 1) ? " " : 8'd9);
			11: add_byte(8'($urandom));
			12: add_end();
			default: add_byte(" ");
		endcase
	endtask

	task build_stimulus();
		add_text("if ELSE x9 12 3.25e-2 1. 1e+ <=>=!=! ... .. /*\r*/ //c\n\r\"a\\n\\q\"");
		add_byte(8'hE2); add_byte(8'h89); add_byte(8'hA0);
		add_byte(8'hC3); add_byte(8'hA9);
		add_byte(8'hFF); add_byte("@");
		add_text("\r\n\n\r\r");
		add_end();
		add_text("\"op");
		add_end();
		add_byte(8'hF0);
		add_end();
		add_text("99999999999999999999 0.1234567890123456789012 1e99999 1e-99999");
		add_end();
		while (text_items.size() < ITEM_TARGET) add_fragment();
		add_end();
	endtask

	task send_text();
		foreach (text_items[i]) begin
			calm = (i > text_items.size() - 60);
			if (!calm && $urandom_range(0, 7) == 0) begin
				s_tvalid <= 0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			s_tvalid <= 1;
			s_tdata <= text_items[i][7:0];
			s_tuser <= text_items[i][8];
			@(posedge clk);
			while (!s_tready) @(posedge clk);
			lexer_model.note_input(text_items[i][7:0], text_items[i][8]);
			taken = i + 1;
		end
		s_tvalid <= 0;
	endtask

	task receive_tokens();
		int hold;
		bit held;
		hold = 0;
		held = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) lexer_model.check_token(m_tuser, m_tdata, m_tlast);
			if (!held && taken >= 150) begin
				held = 1;
				hold = 300;
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				hold = $urandom_range(1, 6) - 1;
				m_tready <= 0;
			end else m_tready <= 1;
		end
	endtask

	initial begin
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = 0;
		s_tuser = 0;
		m_tready = 0;
		cycles = 0;
		taken = 0;
		calm = 0;
		build_stimulus();
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		fork
			receive_tokens();
		join_none
		send_text();
		while (lexer_model.due_tokens.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (lexer_model.errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule

// File: sim.f
+incdir+rtl
rtl/sltok_pkg.sv
rtl/sltok_front.sv
rtl/sltok_fifo.sv
rtl/sltok_back.sv
rtl/script_lexer_token_stream.sv
test/testbench.sv
